/* rtl/positional_insert_delete_array_defines.svh */
// assertion macros shared by the checker files of the positional insert/delete array
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define PIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/pida_pkg.sv */
// shared types and constants of the positional insert/delete array
// depends on nothing; used by every module of the block
`default_nettype none

package pida_pkg;

    // field widths of the stream payloads
    localparam int CMD_W       = 3;
    localparam int POS_W       = 8;
    localparam int WORD_W      = 32;
    localparam int COUNT_OUT_W = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // default array depth and read gather group size
    localparam int DEF_CAPACITY = 128;
    localparam int GROUP_SIZE   = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // action broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_READ   = 2'd3
    } cell_op_t;

endpackage

`default_nettype wire

/* rtl/pida_cell.sv */
// one storage cell of the array row: holds one word, shifts with its neighbors
// depends on pida_pkg
`default_nettype none

module pida_cell #(
    parameter int SLOT_W = 7,
    parameter int INDEX  = 0
) (
    input  wire logic                        clk,
    input  wire pida_pkg::cell_op_t          op,
    input  wire logic [SLOT_W-1:0]           slot,
    input  wire logic [pida_pkg::WORD_W-1:0] element,
    input  wire logic [pida_pkg::WORD_W-1:0] left_word,
    input  wire logic [pida_pkg::WORD_W-1:0] right_word,
    output logic      [pida_pkg::WORD_W-1:0] word,
    output logic      [pida_pkg::WORD_W-1:0] rd_word
);
    import pida_pkg::*;

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              here;
    logic              above;

    assign here  = (slot == IDX);
    assign above = (IDX > slot);

    // next content from the broadcast action
    always_comb
    begin
        word_next = word_reg;
        case (op)
            CELL_INSERT:
            begin
                if (here)
                    word_next = element;
                else if (above)
                    word_next = left_word;
            end
            CELL_DELETE:
            begin
                if (here || above)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    // only the addressed cell drives its word onto the read gather
    assign rd_word = (op == CELL_READ && here) ? word_reg : '0;

endmodule

`default_nettype wire

/* rtl/pida_gather.sv */
// registered or-reduction of one group of cell read words
// depends on pida_pkg
`default_nettype none

module pida_gather #(
    parameter int N = 16
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [pida_pkg::WORD_W-1:0] words [N],
    output logic      [pida_pkg::WORD_W-1:0] group_word
);
    import pida_pkg::*;

    logic [WORD_W-1:0] group_reg;
    logic [WORD_W-1:0] group_next;

    // at most one word in the group is nonzero
    always_comb
    begin
        group_next = '0;
        for (int i = 0; i < N; i++)
        begin
            group_next = group_next | words[i];
        end
    end

    // capture when the pipeline stage loads
    always_ff @(posedge clk)
    begin
        if (en)
            group_reg <= group_next;
    end

    assign group_word = group_reg;

endmodule

`default_nettype wire

/* rtl/positional_insert_delete_array.sv */
// Results pass through stage a and then the output register, which lets the next input
// transfer while a result waits. Throughput: one item per cycle unless the output stalls;
// every command, insert and delete included, updates the whole cell row as it is accepted,
// and a read gathers through two or-levels, into stage a and then the output register.
// Reset: entry count cleared and both pipeline stages empty; stored words stay undefined.
// top level of the positional insert/delete array; depends on pida_pkg, pida_cell, pida_gather
`default_nettype none

module positional_insert_delete_array #(
    parameter int CAPACITY = pida_pkg::DEF_CAPACITY
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command[2:0], position[10:3], element[42:11], zero pad above
    input  wire logic [pida_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // success[0], read_value[32:1], entry_count[40:33], zero pad above
    output logic      [pida_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);
    import pida_pkg::*;

    localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;
    localparam int OUT_USED_W = 1 + WORD_W + COUNT_OUT_W;

    // input fields
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] element;

    assign command  = s_tdata[CMD_W-1:0];
    assign position = s_tdata[CMD_W +: POS_W];
    assign element  = s_tdata[CMD_W+POS_W +: WORD_W];

    // control registers
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   valid_a_reg;
    logic                   valid_a_next;
    logic                   valid_o_reg;
    logic                   valid_o_next;

    // payload registers
    logic                   success_a_reg;
    logic [COUNT_OUT_W-1:0] count_a_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic in_xfer;
    logic advance_a;

    // decode
    logic [CMP_W-1:0]  cnt_e;
    logic [CMP_W-1:0]  pos_e;
    logic [CMP_W-1:0]  pos_m1;
    logic [CMP_W-1:0]  cnt_after;
    logic              pos_ok;
    logic              rd_ok;
    logic              ins_ok;
    logic              not_full;
    logic              cmd_ok;
    cell_op_t          op_dec;
    cell_op_t          cell_op;
    logic [SLOT_W-1:0] slot;

    // cell row wiring
    logic [WORD_W-1:0] cell_words [CAPACITY];
    logic [WORD_W-1:0] rd_words   [PAD_CELLS];
    logic [WORD_W-1:0] group_words [NUM_GROUPS];
    logic [WORD_W-1:0] read_word;

    // handshake
    assign advance_a = valid_a_reg && (!valid_o_reg || m_tready);
    assign s_tready  = !valid_a_reg || advance_a;
    assign in_xfer   = s_tvalid && s_tready;

    // command check and cell action
    always_comb
    begin
        cnt_e     = CMP_W'(count_reg);
        pos_e     = CMP_W'(position);
        pos_m1    = pos_e - CMP_W'(1);
        pos_ok    = (position != '0);
        rd_ok     = pos_ok && (pos_e <= cnt_e);
        ins_ok    = pos_ok && (pos_e <= cnt_e + CMP_W'(1));
        not_full  = (cnt_e != CMP_W'(CAPACITY));
        cmd_ok    = 1'b0;
        op_dec    = CELL_HOLD;
        slot      = pos_m1[SLOT_W-1:0];
        cnt_after = cnt_e;
        case (command)
            CMD_CLEAR:
            begin
                cmd_ok    = 1'b1;
                cnt_after = '0;
            end
            CMD_APPEND:
            begin
                if (not_full)
                begin
                    cmd_ok    = 1'b1;
                    op_dec    = CELL_INSERT;
                    slot      = cnt_e[SLOT_W-1:0];
                    cnt_after = cnt_e + CMP_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (not_full && ins_ok)
                begin
                    cmd_ok    = 1'b1;
                    op_dec    = CELL_INSERT;
                    cnt_after = cnt_e + CMP_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (rd_ok)
                begin
                    cmd_ok    = 1'b1;
                    op_dec    = CELL_DELETE;
                    cnt_after = cnt_e - CMP_W'(1);
                end
            end
            CMD_READ:
            begin
                if (rd_ok)
                begin
                    cmd_ok = 1'b1;
                    op_dec = CELL_READ;
                end
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
        cell_op = in_xfer ? op_dec : CELL_HOLD;
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = element;
        end
        else
        begin : g_inner_l
            assign left_w = cell_words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_words[i];
        end
        else
        begin : g_inner_r
            assign right_w = cell_words[i+1];
        end

        pida_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .slot       (slot),
            .element    (element),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_words[i]),
            .rd_word    (rd_words[i])
        );
    end

    // unused gather inputs past the last cell
    for (genvar i = CAPACITY; i < PAD_CELLS; i++)
    begin : g_pad
        assign rd_words[i] = '0;
    end

    // first gather level, registered with stage a
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        pida_gather #(
            .N (GROUP_SIZE)
        ) u_gather (
            .clk        (clk),
            .en         (in_xfer),
            .words      (rd_words[g*GROUP_SIZE +: GROUP_SIZE]),
            .group_word (group_words[g])
        );
    end

    // second gather level
    always_comb
    begin
        read_word = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            read_word = read_word | group_words[g];
        end
    end

    // control next values
    always_comb
    begin
        count_next = in_xfer ? cnt_after[CNT_W-1:0] : count_reg;

        valid_a_next = valid_a_reg;
        if (in_xfer)
            valid_a_next = 1'b1;
        else if (advance_a)
            valid_a_next = 1'b0;

        valid_o_next = valid_o_reg;
        if (advance_a)
            valid_o_next = 1'b1;
        else if (m_tready)
            valid_o_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            valid_a_reg <= valid_a_next;
            valid_o_reg <= valid_o_next;
        end
    end

    // stage a and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            success_a_reg <= cmd_ok;
            count_a_reg   <= cnt_after[COUNT_OUT_W-1:0];
        end
        if (advance_a)
        begin
            out_data_reg <= {(OUT_TDATA_W - OUT_USED_W)'(0), count_a_reg, read_word,
                             success_a_reg};
        end
    end

    assign m_tvalid = valid_o_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/pida_checker.sv */
// port-level checks of the positional insert/delete array, bound to the top level
// depends on pida_pkg and positional_insert_delete_array_defines.svh
`default_nettype none
`include "positional_insert_delete_array_defines.svh"

module pida_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic [pida_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready
);
    import pida_pkg::*;

    // a refused command never reports a word
    `PIDA_ASSERT_IMPLY(a_fail_no_word, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[WORD_W:1] == '0)

    // pad bits above the result fields stay zero
    `PIDA_ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_TDATA_W-1:WORD_W+COUNT_OUT_W+1] == '0)

    // a stalled result stays put
    `PIDA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // with no result waiting the input side always takes a transfer
    `PIDA_ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !m_tvalid, s_tready)

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

/* tb/pida_tb_pkg.sv */
// reply record and shadow copy of the array used by the insert/delete array testbench
// depends on pida_pkg for the command codes, field widths and depth
`default_nettype none

package pida_tb_pkg;

    import pida_pkg::*;

    // one reply of the block, unpacked
    typedef struct {
        logic              success;
        logic [WORD_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0] entry_count;
    } array_reply_t;

    // shadow of the word array and the queue of replies still to come
    class array_shadow;

        bit [WORD_W-1:0] words [DEF_CAPACITY];
        int unsigned     used;
        array_reply_t    awaited [$];
        int unsigned     failures;

        function new();
            used     = 0;
            failures = 0;
        endfunction

        // place a word at a zero-based slot, moving later words up
        function void place_word(int unsigned slot, logic [WORD_W-1:0] word);
            for (int unsigned k = used; k > slot; k--)
                words[k] = words[k-1];
            words[slot] = word;
            used++;
        endfunction

        // apply one accepted command and queue the reply it must produce
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] elem);
            array_reply_t reply;
            reply.success    = 1'b0;
            reply.read_value = '0;
            case (cmd)
                CMD_CLEAR:
                begin
                    used          = 0;
                    reply.success = 1'b1;
                end
                CMD_APPEND:
                begin
                    if (used < DEF_CAPACITY)
                    begin
                        place_word(used, elem);
                        reply.success = 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    if (used < DEF_CAPACITY && pos >= 1 && pos <= used + 1)
                    begin
                        place_word(pos - 1, elem);
                        reply.success = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (pos >= 1 && pos <= used)
                    begin
                        for (int unsigned k = pos - 1; k + 1 < used; k++)
                            words[k] = words[k+1];
                        used--;
                        reply.success = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (pos >= 1 && pos <= used)
                    begin
                        reply.read_value = words[pos-1];
                        reply.success    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            reply.entry_count = used[COUNT_OUT_W-1:0];
            awaited.push_back(reply);
        endfunction

        // compare one output transfer against the oldest awaited reply
        function void check_reply(logic [OUT_TDATA_W-1:0] tdata);
            array_reply_t want;
            logic              got_success;
            logic [WORD_W-1:0] got_value;
            logic [COUNT_OUT_W-1:0] got_count;
            got_success = tdata[0];
            got_value   = tdata[WORD_W:1];
            got_count   = tdata[WORD_W+COUNT_OUT_W:WORD_W+1];
            if (awaited.size() == 0)
            begin
                $error("unexpected reply transfer: tdata %h", tdata);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got_success !== want.success)
            begin
                $error("success: expected %0b, actual %0b", want.success, got_success);
                failures++;
            end
            if (got_value !== want.read_value)
            begin
                $error("read_value: expected %h, actual %h", want.read_value, got_value);
                failures++;
            end
            if (got_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", want.entry_count, got_count);
                failures++;
            end
        endfunction

    endclass

endpackage

`default_nettype wire

/* tb/tb.sv */
// testbench of positional_insert_delete_array: directed and random command streams,
// replies checked against a shadow array; depends on pida_pkg, pida_tb_pkg and the rtl
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pida_pkg::*;
    import pida_tb_pkg::*;

    localparam int          ITEM_TARGET  = 1050;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          HOLD_AT      = 300;
    localparam int          PAUSE_AT     = 600;
    localparam int          QUIET_AT     = 900;
    localparam int          SETTLE       = 10;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [CMD_W-1:0] CMD_TOP = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    array_shadow shadow = new();
    int unsigned accepted = 0;
    int unsigned cycles = 0;
    bit          idling_on = 1'b1;
    bit          hold_request = 1'b0;

    positional_insert_delete_array i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** positional_insert_delete_array: FAILED **");
            $finish;
        end
    end

    // offer one command until it transfers, with an optional gap before it
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                logic [WORD_W-1:0] elem);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-CMD_W-POS_W-WORD_W){1'b0}}, elem, pos, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.note_command(cmd, pos, elem);
        accepted++;
    endtask

    // hold the input side idle until every awaited reply has come back
    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
    endtask

    // position inside the used range most of the time, anything at all otherwise
    function automatic logic [POS_W-1:0] pick_position(int unsigned upper);
        if (upper == 0 || $urandom_range(0, 7) == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return POS_W'($urandom_range(1, upper));
    endfunction

    // mixed traffic with mostly valid positions
    task automatic send_mixed();
        int unsigned n;
        int unsigned pick;
        n = $urandom_range(10, 40);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_command(CMD_APPEND, POS_W'($urandom), $urandom);
            else if (pick < 50)
                send_command(CMD_INSERT, pick_position(shadow.used + 1), $urandom);
            else if (pick < 70)
                send_command(CMD_DELETE, pick_position(shadow.used), $urandom);
            else
                send_command(CMD_READ, pick_position(shadow.used), $urandom);
        end
    endtask

    // grow the array to full, then try to add past the end and read back
    task automatic send_fill();
        while (shadow.used < DEF_CAPACITY)
        begin
            if ($urandom_range(0, 1) == 0)
                send_command(CMD_APPEND, POS_W'($urandom), $urandom);
            else
                send_command(CMD_INSERT, POS_W'($urandom_range(1, shadow.used + 1)),
                             $urandom);
        end
        send_command(CMD_APPEND, POS_W'($urandom), $urandom);
        send_command(CMD_INSERT, POS_W'($urandom_range(1, DEF_CAPACITY + 1)), $urandom);
        send_command(CMD_READ, POS_W'(DEF_CAPACITY), $urandom);
        send_command(CMD_READ, POS_W'(DEF_CAPACITY + 1), $urandom);
        send_command(CMD_DELETE, POS_W'(DEF_CAPACITY), $urandom);
        repeat ($urandom_range(2, 6))
            send_command(CMD_READ, pick_position(shadow.used), $urandom);
    endtask

    // shrink the array by deletes at random places, with reads mixed in
    task automatic send_shrink();
        int unsigned floor_count;
        floor_count = $urandom_range(0, 8);
        while (shadow.used > floor_count)
        begin
            if ($urandom_range(0, 3) == 0)
                send_command(CMD_READ, POS_W'($urandom_range(1, shadow.used)), $urandom);
            send_command(CMD_DELETE, POS_W'($urandom_range(1, shadow.used)), $urandom);
        end
    endtask

    // fully random commands, unknown codes included
    task automatic send_noise();
        repeat ($urandom_range(5, 10))
            send_command(CMD_W'($urandom_range(0, CMD_TOP)), POS_W'($urandom), $urandom);
    endtask

    // reply side: ready in random stretches, stalls in bursts, one long hold
    task automatic take_cycle();
        @(posedge clk);
        if (m_tvalid && m_tready)
            shadow.check_reply(m_tdata);
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) take_cycle();
            end
            else if (idling_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) take_cycle();
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) take_cycle();
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        bit          hold_done;
        bit          pause_done;
        int unsigned pick;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty array, edges of words and positions, unknown codes
        send_command(CMD_READ,   8'd1,   32'h0000_0000);
        send_command(CMD_DELETE, 8'd1,   32'hFFFF_FFFF);
        send_command(CMD_INSERT, 8'd0,   32'h1111_1111);
        send_command(CMD_INSERT, 8'd2,   32'h2222_2222);
        send_command(CMD_INSERT, 8'd1,   32'h8000_0000);
        send_command(CMD_APPEND, 8'd255, 32'h7FFF_FFFF);
        send_command(CMD_APPEND, 8'd0,   32'h0000_0000);
        send_command(CMD_APPEND, 8'd0,   32'hFFFF_FFFF);
        send_command(CMD_INSERT, 8'd2,   32'h1234_5678);
        send_command(CMD_INSERT, 8'd6,   32'hA5A5_5A5A);
        send_command(CMD_INSERT, 8'd8,   32'h0BAD_0BAD);
        send_command(CMD_READ,   8'd1,   32'h0000_0000);
        send_command(CMD_READ,   8'd6,   32'h0000_0000);
        send_command(CMD_READ,   8'd7,   32'h0000_0000);
        send_command(CMD_READ,   8'd0,   32'h0000_0000);
        send_command(CMD_READ,   8'd255, 32'hFFFF_FFFF);
        send_command(CMD_DELETE, 8'd6,   32'h0000_0000);
        send_command(CMD_DELETE, 8'd1,   32'h0000_0000);
        send_command(CMD_DELETE, 8'd2,   32'h0000_0000);
        send_command(CMD_DELETE, 8'd0,   32'h0000_0000);
        send_command(CMD_INSERT + CMD_INSERT + CMD_APPEND, 8'd1, 32'hFFFF_FFFF);
        send_command(CMD_TOP - CMD_APPEND, 8'd2, 32'h5555_5555);
        send_command(CMD_TOP, 8'd255, 32'hAAAA_AAAA);
        send_command(CMD_CLEAR,  8'd170, 32'h5555_AAAA);
        send_command(CMD_READ,   8'd1,   32'h0000_0000);
        wait_replies_drained();

        // random segments
        while (accepted < ITEM_TARGET)
        begin
            if (!hold_done && accepted >= HOLD_AT)
            begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
            end
            if (!pause_done && accepted >= PAUSE_AT)
            begin
                pause_done = 1'b1;
                wait_replies_drained();
            end
            if (accepted >= QUIET_AT)
                idling_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_mixed();
            else if (pick < 60)
                send_fill();
            else if (pick < 75)
                send_shrink();
            else if (pick < 90)
                send_noise();
            else
                send_command(CMD_CLEAR, POS_W'($urandom), $urandom);
        end

        // wait out the replies, then keep watching for any stray transfer
        wait_replies_drained();
        repeat (SETTLE) @(posedge clk);
        if (shadow.awaited.size() != 0)
        begin
            $error("%0d replies never arrived", shadow.awaited.size());
            shadow.failures++;
        end
        if (shadow.failures == 0)
            $display("** positional_insert_delete_array: PASSED **");
        else
            $display("** positional_insert_delete_array: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
